@@ rtl/urem32_pkg.sv @@
// ----------------------------------------------------------------------------
// urem32_pkg
// shared types for the unsigned remainder core and its bit cells
// ----------------------------------------------------------------------------
package urem32_pkg;

    // per-cycle control that the sequencer broadcasts to every bit cell
    typedef struct packed {
        logic load;     // capture a new item, clear the partial remainder
        logic shift;    // take one restoring step
        logic sub;      // keep the difference rather than the shifted value
    } cell_ctrl_t;

endpackage

@@ rtl/unsigned_remainder_32_core.sv @@
// ----------------------------------------------------------------------------
// unsigned_remainder_32_core
// unsigned remainder by radix-2 restoring division over a row of bit cells
// ----------------------------------------------------------------------------
// usage
//   raise start with numerator and modulus; the item is taken at a rising
//   edge where start is high and busy is low
//   busy is high while the cells step, one remainder bit decided per cycle;
//   each cell hands its remainder bit to the next cell up and the borrow of
//   the subtract ripples along the row
//   done pulses for one cycle with remainder_out = numerator mod modulus,
//   or 0 when modulus is zero; it is not held and cannot be stalled
//   done is registered: it is set at the edge that ends the last step, and
//   remainder_out holds the result while done is shown
//   items do not overlap: a new item is taken only while busy is low; a new
//   item may be started in the cycle that done is shown
//   reset (rst_n low, asynchronous) drops busy and done; any item in flight
//   is lost and no result is shown for it
// ----------------------------------------------------------------------------
module unsigned_remainder_32_core #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] numerator,
    input  logic [DATA_WIDTH-1:0] modulus,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] remainder_out
);
    import urem32_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH) + 1;
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(DATA_WIDTH);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;
    logic             zero_div_reg;
    logic             zero_div_next;

    logic                  accept;
    cell_ctrl_t            ctrl;
    logic [DATA_WIDTH:0]   borrow;     // borrow chain through the row
    logic [DATA_WIDTH-1:0] rem;        // partial remainder, one bit per cell
    logic [DATA_WIDTH-1:0] num;        // dividend shift line, one bit per cell
    logic [DATA_WIDTH-1:0] rem_in;
    logic [DATA_WIDTH-1:0] num_in;

    assign accept = start && (state_reg == ST_IDLE);

    // subtract when the shifted-out carry is set or shifted >= divisor
    assign ctrl.load  = accept;
    assign ctrl.shift = (state_reg == ST_RUN);
    assign ctrl.sub   = rem[DATA_WIDTH-1] || !borrow[DATA_WIDTH];

    assign borrow[0] = 1'b0;

    // lowest cell takes the next dividend bit, every other cell its neighbor's
    always_comb
    begin
        rem_in = {rem[DATA_WIDTH-2:0], num[DATA_WIDTH-1]};
        num_in = {num[DATA_WIDTH-2:0], 1'b0};
    end

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        urem32_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .num_load   (numerator[i]),
            .div_load   (modulus[i]),
            .rem_in     (rem_in[i]),
            .num_in     (num_in[i]),
            .borrow_in  (borrow[i]),
            .borrow_out (borrow[i+1]),
            .rem        (rem[i]),
            .num        (num[i])
        );
    end

    // sequencer: load, DATA_WIDTH steps, then one done cycle
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        done_next     = 1'b0;
        zero_div_next = zero_div_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next    = ST_RUN;
                    cnt_next      = STEPS;
                    zero_div_next = (modulus == '0);
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg - LAST;
                if (cnt_reg == LAST)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            done_reg     <= 1'b0;
            zero_div_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            done_reg     <= done_next;
            zero_div_reg <= zero_div_next;
        end
    end

    assign busy          = (state_reg == ST_RUN);
    assign done          = done_reg;
    // a zero divisor leaves the dividend in the row; report zero instead
    assign remainder_out = zero_div_reg ? '0 : rem;

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("done shown while still stepping");

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && (cnt_reg == STEPS))
        else $error("accepted item did not start a full run");

    a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy && (cnt_reg == LAST) |=> done_reg)
        else $error("last step not followed by done");

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy))
        else $error("done without a run before it");

    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (cnt_reg != '0))
        else $error("step counter empty while busy");
`endif

endmodule

@@ rtl/urem32_cell.sv @@
// ----------------------------------------------------------------------------
// urem32_cell
// one bit slice of the restoring divider: remainder, divisor and dividend bit
// ----------------------------------------------------------------------------
module urem32_cell (
    input  logic                   clk,
    input  urem32_pkg::cell_ctrl_t ctrl,
    input  logic                   num_load,   // dividend bit on load
    input  logic                   div_load,   // divisor bit on load
    input  logic                   rem_in,     // remainder bit from lower neighbor (cell 0: next dividend bit)
    input  logic                   num_in,     // dividend bit from lower neighbor
    input  logic                   borrow_in,
    output logic                   borrow_out,
    output logic                   rem,
    output logic                   num
);
    import urem32_pkg::*;

    logic rem_reg;
    logic rem_next;
    logic num_reg;
    logic num_next;
    logic div_reg;
    logic diff;

    // one bit of shifted - divisor
    assign diff       = rem_in ^ div_reg ^ borrow_in;
    assign borrow_out = (~rem_in & div_reg) | (~(rem_in ^ div_reg) & borrow_in);

    always_comb
    begin
        rem_next = rem_reg;
        num_next = num_reg;
        if (ctrl.load)
        begin
            rem_next = 1'b0;
            num_next = num_load;
        end
        else if (ctrl.shift)
        begin
            rem_next = ctrl.sub ? diff : rem_in;
            num_next = num_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        if (ctrl.load)
        begin
            div_reg <= div_load;
        end
    end

    assign rem = rem_reg;
    assign num = num_reg;

endmodule
